// ===== sv/pgsdc_pkg.sv =====
package pgsdc_pkg;

    // Defaults for the top level parameters
    localparam int CHANNELS_DEF    = 2;
    localparam int SAMPLE_BITS_DEF = 24;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_STEP       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POLARITY_INVERT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEW_LIMIT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DC_ALPHA        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LEVEL    = 3'd4;

    // Register reset values
    localparam logic [3:0]  GAIN_STEP_RST    = 4'd6;
    localparam logic [30:0] SLEW_LIMIT_RST   = 31'd120149333;
    localparam logic [24:0] DC_ALPHA_RST     = 25'd2196;
    localparam logic [16:0] OUTPUT_LEVEL_RST = 17'd65536;

    // Saturation limits and fixed widths of the Q6.18 datapath
    localparam logic [24:0] ALPHA_ONE = 25'd16777216;
    localparam logic [16:0] LEVEL_ONE = 17'd65536;
    localparam int          OUT_W     = 24;
    localparam logic signed [31:0] CLIP_Q18 = 32'sd5636096;

    // Sequencer states, one multiplier use per MUL_* state
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_GAIN,
        ST_SLEW,
        ST_DC_ERR,
        ST_MUL_HI,
        ST_MUL_LO,
        ST_DC_UPD,
        ST_CLIP,
        ST_MUL_ATT,
        ST_OUT
    } t_state;

    // Operand select of the shared multiplier
    typedef enum logic [1:0] {
        MUL_GAIN,
        MUL_DC_HI,
        MUL_DC_LO,
        MUL_ATT
    } t_mul_sel;

    // Controller to datapath commands
    typedef struct packed {
        logic     accept;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     slew_en;
        logic     dce_en;
        logic     acc_en;
        logic     dc_en;
        logic     clip_en;
        logic     out_load;
    } t_cmd;

    // Gain table, round(10^(dB/20)*256) for 5..60 dB; steps above 11 saturate
    function automatic logic [17:0] gain_lut(input logic [3:0] idx);
        logic [17:0] g;
        case (idx)
            4'd0:    g = 18'd455;
            4'd1:    g = 18'd810;
            4'd2:    g = 18'd1440;
            4'd3:    g = 18'd2560;
            4'd4:    g = 18'd4552;
            4'd5:    g = 18'd8095;
            4'd6:    g = 18'd14396;
            4'd7:    g = 18'd25600;
            4'd8:    g = 18'd45524;
            4'd9:    g = 18'd80954;
            4'd10:   g = 18'd143959;
            default: g = 18'd256000;
        endcase
        return g;
    endfunction

endpackage

// ===== sv/pgsdc_ctrl.sv =====
module pgsdc_ctrl
    import pgsdc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    output logic o_valid,
    input  logic i_stall,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;

    // State and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.mul_sel = MUL_GAIN;
        n_ovalid = r_ovalid && i_stall;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_MUL_GAIN;
                end
            end
            ST_MUL_GAIN: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_GAIN;
                n_state       = ST_SLEW;
            end
            ST_SLEW: begin
                o_cmd.slew_en = 1'b1;
                n_state       = ST_DC_ERR;
            end
            ST_DC_ERR: begin
                o_cmd.dce_en = 1'b1;
                n_state      = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_DC_HI;
                n_state       = ST_MUL_LO;
            end
            ST_MUL_LO: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_DC_LO;
                o_cmd.acc_en  = 1'b1;
                n_state       = ST_DC_UPD;
            end
            ST_DC_UPD: begin
                o_cmd.dc_en = 1'b1;
                n_state     = ST_CLIP;
            end
            ST_CLIP: begin
                o_cmd.clip_en = 1'b1;
                n_state       = ST_MUL_ATT;
            end
            ST_MUL_ATT: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_ATT;
                n_state       = ST_OUT;
            end
            ST_OUT: begin
                // load once the output register is free or drains this cycle
                if (!r_ovalid || !i_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_ovalid       = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_ovalid;

endmodule

// ===== sv/pgsdc_dp.sv =====
module pgsdc_dp
    import pgsdc_pkg::*;
#(
    parameter int CHANNELS    = CHANNELS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cmd                          i_cmd,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    input  logic                          i_channel,
    input  logic                          i_block_start,
    input  logic                          i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    output logic signed [OUT_W-1:0]       o_sample_out,
    output logic                          o_clip_active
);

    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int S_W    = SAMPLE_BITS + 1;
    localparam int MA_W   = (S_W > 26) ? S_W : 26;
    localparam int MB_W   = 20;
    localparam int P_W    = MA_W + MB_W;
    localparam int GSH    = SAMPLE_BITS - 11;
    localparam int X_W    = 29;
    localparam int DC_W   = 40;
    localparam int E_W    = 39;
    localparam int E_SPL  = 19;
    localparam int ACC_W  = 64;
    localparam logic signed [P_W-1:0] GAIN_HALF = P_W'(1) <<< (GSH - 1);
    localparam logic signed [P_W-1:0] ATT_HALF  = P_W'(1) <<< 15;

    // Configuration registers
    logic [3:0]  r_gain_step;
    logic        r_pol;
    logic [30:0] r_slew;
    logic [24:0] r_alpha;
    logic [16:0] r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_step <= GAIN_STEP_RST;
            r_pol       <= 1'b0;
            r_slew      <= SLEW_LIMIT_RST;
            r_alpha     <= DC_ALPHA_RST;
            r_level     <= OUTPUT_LEVEL_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_GAIN_STEP:       r_gain_step <= i_cfg_data[3:0];
                CFG_POLARITY_INVERT: r_pol       <= i_cfg_data[0];
                CFG_SLEW_LIMIT:      r_slew      <= i_cfg_data[30:0];
                CFG_DC_ALPHA:        r_alpha     <= i_cfg_data[24:0];
                CFG_OUTPUT_LEVEL:    r_level     <= i_cfg_data[16:0];
                default:             ;
            endcase
        end
    end

    logic [24:0] w_alpha;
    logic [16:0] w_level;
    assign w_alpha = (r_alpha > ALPHA_ONE) ? ALPHA_ONE : r_alpha;
    assign w_level = (r_level > LEVEL_ONE) ? LEVEL_ONE : r_level;

    // Working registers
    logic signed [S_W-1:0]   r_s;
    logic [CH_W-1:0]         r_ch;
    logic signed [P_W-1:0]   r_prod;
    logic signed [X_W-1:0]   r_x;
    logic signed [E_W-1:0]   r_e;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [OUT_W-1:0] r_y;
    logic                    r_clip;
    logic signed [OUT_W-1:0] r_sample_out;
    logic                    r_clip_out;

    // Per-channel state
    logic signed [X_W-1:0]  r_last [CHANNELS];
    logic signed [DC_W-1:0] r_dc   [CHANNELS];

    // Shared multiplier operand select
    logic signed [MA_W-1:0] w_a;
    logic signed [MB_W-1:0] w_b;
    logic signed [P_W-1:0]  w_mul;

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_GAIN: begin
                w_a = MA_W'(r_s);
                w_b = $signed({2'b00, gain_lut(r_gain_step)});
            end
            MUL_DC_HI: begin
                w_a = MA_W'($signed({1'b0, w_alpha}));
                w_b = r_e[E_W-1:E_SPL];
            end
            MUL_DC_LO: begin
                w_a = MA_W'($signed({1'b0, w_alpha}));
                w_b = $signed({1'b0, r_e[E_SPL-1:0]});
            end
            MUL_ATT: begin
                w_a = MA_W'(r_y);
                w_b = $signed({3'b000, w_level});
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    assign w_mul = w_a * w_b;

    // Gain rounding and slew limit
    logic signed [P_W-1:0] w_gsum, w_gshift;
    logic signed [X_W-1:0] w_x;
    logic signed [31:0]    w_diff, w_lim, w_dlim, w_xn;

    always_comb begin
        w_gsum   = r_prod + GAIN_HALF;
        w_gshift = w_gsum >>> GSH;
        w_x      = w_gshift[X_W-1:0];
        w_diff   = 32'(w_x) - 32'(r_last[r_ch]);
        w_lim    = $signed({1'b0, r_slew});
        if (w_diff > w_lim) begin
            w_dlim = w_lim;
        end else if (w_diff < -w_lim) begin
            w_dlim = -w_lim;
        end else begin
            w_dlim = w_diff;
        end
        w_xn = 32'(r_last[r_ch]) + w_dlim;
    end

    // DC error, estimate update, removal and clip
    logic signed [DC_W-1:0]  w_e;
    logic signed [ACC_W-1:0] w_sum, w_rnd;
    logic signed [DC_W-1:0]  w_dcn, w_dcr;
    logic signed [31:0]      w_y;

    always_comb begin
        w_e   = (DC_W'(r_x) <<< 8) - r_dc[r_ch];
        w_sum = r_acc + ACC_W'(r_prod);
        w_rnd = (w_sum + 64'sd8388608) >>> 24;
        w_dcn = r_dc[r_ch] + w_rnd[DC_W-1:0];
        w_dcr = (r_dc[r_ch] + 40'sd128) >>> 8;
        w_y   = 32'(r_x) - w_dcr[31:0];
    end

    // Attenuation rounding
    logic signed [P_W-1:0] w_att;
    assign w_att = (r_prod + ATT_HALF) >>> 16;

    // Sample intake and arithmetic steps
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_s  <= r_pol ? -S_W'(i_sample_in) : S_W'(i_sample_in);
            r_ch <= (CHANNELS > 1) ? CH_W'(i_channel) : '0;
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_mul;
        end
        if (i_cmd.slew_en) begin
            r_x <= w_xn[X_W-1:0];
        end
        if (i_cmd.dce_en) begin
            r_e <= w_e[E_W-1:0];
        end
        if (i_cmd.acc_en) begin
            r_acc <= ACC_W'(r_prod) <<< E_SPL;
        end
        if (i_cmd.clip_en) begin
            if (w_y > CLIP_Q18) begin
                r_y <= OUT_W'(CLIP_Q18);
            end else if (w_y < -CLIP_Q18) begin
                r_y <= OUT_W'(-CLIP_Q18);
            end else begin
                r_y <= w_y[OUT_W-1:0];
            end
        end
        if (i_cmd.out_load) begin
            r_sample_out <= w_att[OUT_W-1:0];
            r_clip_out   <= r_clip;
        end
    end

    // Channel state and sticky clip flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_last[i] <= '0;
                r_dc[i]   <= '0;
            end
            r_clip <= 1'b0;
        end else begin
            if (i_cmd.slew_en) begin
                r_last[r_ch] <= w_xn[X_W-1:0];
            end
            if (i_cmd.dc_en) begin
                r_dc[r_ch] <= w_dcn;
            end
            if (i_cmd.accept && i_block_start) begin
                r_clip <= 1'b0;
            end else if (i_cmd.clip_en && (w_y > CLIP_Q18 || w_y < -CLIP_Q18)) begin
                r_clip <= 1'b1;
            end
        end
    end

    assign o_sample_out  = r_sample_out;
    assign o_clip_active = r_clip_out;

endmodule

// ===== sv/preamp_gain_slew_dc_clip.sv =====
// Microphone preamp channel: polarity, stepped gain, slew limit, DC servo,
// hard clip at +-21.5 with a sticky flag, and output attenuation, in Q6.18.
// Input channel: i_valid with o_stall; a sample with its channel and block
// start mark is taken at a clock edge where i_valid is high and o_stall low.
// Output channel: o_valid with i_stall; one result per input sample.
// Configuration: i_cfg_valid / o_cfg_ready with register index and data;
// write only while no sample is in flight. Unknown indexes are ignored.
// o_stall stays high from the input transaction until the result is loaded
// into the output register, so a sample is taken only after the previous
// one is finished. The sequencer steps through one shared multiplier,
// used four times per sample (gain, two DC partial products, attenuation),
// with the rounding, slew and clip steps between the uses.
// A finished result sits in the output register while the next sample is
// taken; if the receiver still stalls when the next one is done, the block
// holds it and keeps o_stall high until the output register frees up.
// Reset: synchronous active low; clears per-channel last value and DC
// estimate, the clip flag and the configuration registers to defaults, no
// clearing pass. Stalls only delay delivery; no result is lost or repeated.
module preamp_gain_slew_dc_clip
    import pgsdc_pkg::*;
#(
    parameter int CHANNELS    = CHANNELS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    input  logic                          i_channel,
    input  logic                          i_block_start,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [OUT_W-1:0]       o_sample_out,
    output logic                          o_clip_active,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data
);

    t_cmd w_cmd;

    pgsdc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (w_cmd)
    );

    pgsdc_dp #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_sample_in   (i_sample_in),
        .i_channel     (i_channel),
        .i_block_start (i_block_start),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_sample_out  (o_sample_out),
        .o_clip_active (o_clip_active)
    );

    // Configuration writes never wait
    assign o_cfg_ready = 1'b1;

    // An accepted sample starts with the gain multiply
    a_accept_to_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (w_cmd.mul_en && w_cmd.mul_sel == MUL_GAIN))
        else $error("gain multiply did not follow an accepted sample");

    // A result is never loaded over one the receiver has not taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_valid || !i_stall))
        else $error("output register overwritten while stalled");

    // Intake stays closed while a sample is being processed
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.mul_en || w_cmd.slew_en || w_cmd.dc_en || w_cmd.out_load) |-> o_stall)
        else $error("input open while a sample is in flight");

    // Delivered samples stay within the clip range
    a_clip_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_sample_out) <= CLIP_Q18 && 32'(o_sample_out) >= -CLIP_Q18))
        else $error("output sample outside clip range");

endmodule
